// ===== design/ahsfr_pkg.sv =====
package ahsfr_pkg;

    // result item kinds
    typedef enum logic [1:0] {
        KIND_BYTE    = 2'd0,
        KIND_GOOD    = 2'd1,
        KIND_SUM_ERR = 2'd2,
        KIND_LEN_ERR = 2'd3
    } t_kind;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_REALTIME_MODE  = 2'd0,
        CFG_START_RESPONSE = 2'd1,
        CFG_START_COMMAND  = 2'd2,
        CFG_END_FRAME      = 2'd3
    } t_cfg_index;

    localparam int BYTE_W          = 8;
    localparam int LEN_W           = 11;
    localparam int MAX_FRAME_BYTES = 1024;
    localparam int COUNT_LIMIT_INT = (MAX_FRAME_BYTES < 2047) ? MAX_FRAME_BYTES : 2047;
    localparam logic [LEN_W-1:0] COUNT_LIMIT = LEN_W'(COUNT_LIMIT_INT);
    localparam logic [LEN_W-1:0] MIN_CHECKED_LEN = LEN_W'(3);

    localparam logic [3:0]        SYNC_NIBBLE    = 4'hD;
    localparam logic [BYTE_W-1:0] HEX_DIGIT_BASE = 8'h30;
    localparam logic [BYTE_W-1:0] HEX_ALPHA_BASE = 8'h41;

    localparam logic [BYTE_W-1:0] RESET_START_RESPONSE = 8'h01;
    localparam logic [BYTE_W-1:0] RESET_START_COMMAND  = 8'h1B;
    localparam logic [BYTE_W-1:0] RESET_END_FRAME      = 8'h0D;

    typedef struct packed {
        logic              realtime_mode;
        logic [BYTE_W-1:0] start_response_char;
        logic [BYTE_W-1:0] start_command_char;
        logic [BYTE_W-1:0] end_frame_char;
    } t_cfg;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] frame_byte;
        logic [LEN_W-1:0]  frame_length;
    } t_result;

    // results produced by one request, in order
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_core_out;

endpackage

// ===== design/ahsfr_cfg.sv =====
module ahsfr_cfg
    import ahsfr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [BYTE_W-1:0] i_cfg_data,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.realtime_mode       <= 1'b0;
            r_cfg.start_response_char <= RESET_START_RESPONSE;
            r_cfg.start_command_char  <= RESET_START_COMMAND;
            r_cfg.end_frame_char      <= RESET_END_FRAME;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_REALTIME_MODE:  r_cfg.realtime_mode       <= i_cfg_data[0];
                CFG_START_RESPONSE: r_cfg.start_response_char <= i_cfg_data;
                CFG_START_COMMAND:  r_cfg.start_command_char  <= i_cfg_data;
                CFG_END_FRAME:      r_cfg.end_frame_char      <= i_cfg_data;
                default:            r_cfg.realtime_mode       <= r_cfg.realtime_mode;
            endcase
        end
    end

endmodule

// ===== design/ahsfr_core.sv =====
module ahsfr_core
    import ahsfr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_proc,
    output t_core_out         o_out
);

    logic [LEN_W-1:0]  r_count, n_count;
    logic [BYTE_W-1:0] r_sum, n_sum;
    logic [BYTE_W-1:0] r_last, n_last;
    logic [BYTE_W-1:0] r_second, n_second;
    logic              r_resp_open, n_resp_open;
    logic              r_cmd_open, n_cmd_open;
    logic              r_end_seen, n_end_seen;
    logic              r_ovf, n_ovf;

    function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] nib);
        logic [BYTE_W-1:0] wide;
        wide = {4'd0, nib};
        hex_char = (nib < 4'd10) ? (wide + HEX_DIGIT_BASE)
                                 : (wide - 8'd10 + HEX_ALPHA_BASE);
    endfunction

    function automatic t_result byte_result(input logic [BYTE_W-1:0] b);
        t_result r;
        r.kind         = KIND_BYTE;
        r.frame_byte   = b;
        r.frame_length = '0;
        byte_result = r;
    endfunction

    function automatic t_result end_result(input t_kind k, input logic [LEN_W-1:0] len);
        t_result r;
        r.kind         = k;
        r.frame_byte   = '0;
        r.frame_length = len;
        end_result = r;
    endfunction

    always_comb begin
        logic              do_store;
        logic              is_resp, is_cmd, is_end;
        logic [BYTE_W-1:0] chk;
        t_kind             verdict;

        n_count     = r_count;
        n_sum       = r_sum;
        n_last      = r_last;
        n_second    = r_second;
        n_resp_open = r_resp_open;
        n_cmd_open  = r_cmd_open;
        n_end_seen  = r_end_seen;
        n_ovf       = r_ovf;
        o_out.count = 2'd0;
        o_out.res0  = byte_result(i_byte);
        o_out.res1  = byte_result(i_byte);
        do_store    = 1'b0;
        is_resp     = i_byte == i_cfg.start_response_char;
        is_cmd      = !is_resp && (i_byte == i_cfg.start_command_char);
        is_end      = !is_resp && !is_cmd && (i_byte == i_cfg.end_frame_char);
        chk         = '0;
        verdict     = KIND_GOOD;

        if (i_cfg.realtime_mode) begin
            // sync byte closes the held frame unchecked, then is stored
            if (i_byte[7:4] == SYNC_NIBBLE && r_count != '0) begin
                o_out.res0  = end_result(r_ovf ? KIND_LEN_ERR : KIND_GOOD, r_count);
                o_out.count = 2'd1;
                n_count     = '0;
                n_sum       = '0;
                n_last      = '0;
                n_second    = '0;
                n_ovf       = 1'b0;
                n_end_seen  = 1'b0;
            end
            do_store = 1'b1;
        end else if (is_resp) begin
            n_resp_open = 1'b1;
            n_end_seen  = 1'b0;
            do_store    = 1'b1;
        end else if (is_cmd) begin
            if (!r_resp_open) begin
                n_cmd_open = 1'b1;
                n_end_seen = 1'b0;
            end
            do_store = 1'b1;
        end else if (is_end) begin
            n_resp_open = 1'b0;
            n_cmd_open  = 1'b0;
            n_end_seen  = 1'b1;
        end else if ((r_resp_open || r_cmd_open) && !r_end_seen) begin
            do_store = 1'b1;
        end

        if (do_store) begin
            if (n_count >= COUNT_LIMIT) begin
                n_ovf = 1'b1;
            end else begin
                n_count = n_count + LEN_W'(1);
                n_sum   = n_sum + i_byte;
            end
            n_second = n_last;
            n_last   = i_byte;
            if (o_out.count == 2'd0) begin
                o_out.res0 = byte_result(i_byte);
            end else begin
                o_out.res1 = byte_result(i_byte);
            end
            o_out.count = o_out.count + 2'd1;
        end

        // checked close in framed mode
        if (!i_cfg.realtime_mode && n_end_seen && !(n_resp_open && n_cmd_open)
            && n_count != '0) begin
            chk = n_sum - n_last - n_second;
            if (n_ovf || n_count < MIN_CHECKED_LEN) begin
                verdict = KIND_LEN_ERR;
            end else if (n_second == hex_char(chk[7:4]) && n_last == hex_char(chk[3:0])) begin
                verdict = KIND_GOOD;
            end else begin
                verdict = KIND_SUM_ERR;
            end
            if (o_out.count == 2'd0) begin
                o_out.res0 = end_result(verdict, n_count);
            end else begin
                o_out.res1 = end_result(verdict, n_count);
            end
            o_out.count = o_out.count + 2'd1;
            n_count     = '0;
            n_sum       = '0;
            n_last      = '0;
            n_second    = '0;
            n_ovf       = 1'b0;
            n_end_seen  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_sum       <= '0;
            r_last      <= '0;
            r_second    <= '0;
            r_resp_open <= 1'b0;
            r_cmd_open  <= 1'b0;
            r_end_seen  <= 1'b0;
            r_ovf       <= 1'b0;
        end else if (i_proc) begin
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_last      <= n_last;
            r_second    <= n_second;
            r_resp_open <= n_resp_open;
            r_cmd_open  <= n_cmd_open;
            r_end_seen  <= n_end_seen;
            r_ovf       <= n_ovf;
        end
    end

endmodule

// ===== design/ahsfr_outq.sv =====
module ahsfr_outq
    import ahsfr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_core_out i_in,
    output logic [1:0] o_free,
    output logic      o_valid,
    input  logic      i_ready,
    output t_result   o_head
);

    t_result    r_q [2];
    t_result    n_q [2];
    logic [1:0] r_count, n_count;
    logic       pop;

    assign pop     = o_valid && i_ready;
    assign o_valid = r_count != 2'd0;
    assign o_head  = r_q[0];
    assign o_free  = 2'd2 - r_count;

    always_comb begin
        n_q     = r_q;
        n_count = r_count;
        if (pop) begin
            n_q[0]  = r_q[1];
            n_count = r_count - 2'd1;
        end
        if (i_push && i_in.count != 2'd0) begin
            n_q[n_count[0]] = i_in.res0;
            if (i_in.count == 2'd2) begin
                n_q[1] = i_in.res1;
            end
            n_count = n_count + i_in.count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

endmodule

// ===== design/ascii_hex_sum_frame_receiver_top.sv =====
// Framed serial byte receiver with ASCII-hex 8-bit sum check. Each request carries one
// received byte. In framed mode a response or command start character opens a frame,
// its bytes are passed out as they arrive (item_kind 0), and the end character closes
// it with a verdict: 1 good, 2 checksum error (last two bytes are not the uppercase
// hex of the sum of the earlier bytes), 3 length error (fewer than three bytes, or more
// than MAX_FRAME_BYTES). In realtime mode every byte is passed out and a byte with high
// nibble 0xD closes the held frame unchecked. Bytes of bad frames appear before their
// verdict. Timing: a byte is held in the input register, then processed into a two-entry
// result queue whose head drives the result port. A byte giving at most one result moves
// on as soon as its result fits, and a new byte is accepted in the same cycle. A byte giving a
// byte and a verdict must find the queue empty and leaves it full, so it holds the input
// until the queue has drained; the single result port drains one result per cycle while
// the result side is ready.
// Configuration writes are always ready and must only be issued while idle.
module ascii_hex_sum_frame_receiver_top
    import ahsfr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration write channel
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [BYTE_W-1:0] i_cfg_data,
    // received byte requests
    input  logic              i_rx_valid,
    output logic              o_rx_ready,
    input  logic [BYTE_W-1:0] i_rx_byte,
    // result requests
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output logic [1:0]        o_item_kind,
    output logic [BYTE_W-1:0] o_frame_byte,
    output logic [LEN_W-1:0]  o_frame_length
);

    t_cfg              cfg;
    t_core_out         core_out;
    t_result           head;
    logic [1:0]        q_free;
    logic              proc;
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;

    // input register: a held byte moves on once its results fit in the queue
    assign proc       = r_in_valid && (core_out.count <= q_free);
    assign o_rx_ready = !r_in_valid || proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_rx_ready) begin
            r_in_valid <= i_rx_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rx_ready && i_rx_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    ahsfr_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // frame tracking, running sum and verdict logic
    ahsfr_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_byte  (r_in_byte),
        .i_proc  (proc),
        .o_out   (core_out)
    );

    // result queue decouples the result port from the input side
    ahsfr_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (proc),
        .i_in    (core_out),
        .o_free  (q_free),
        .o_valid (o_res_valid),
        .i_ready (i_res_ready),
        .o_head  (head)
    );

    assign o_item_kind    = head.kind;
    assign o_frame_byte   = head.frame_byte;
    assign o_frame_length = head.frame_length;

    // queue never holds more than two results
    a_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_free <= 2'd2)
        else $error("result queue overfilled");

    // end items carry no byte and a length within the limit
    a_end_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_item_kind != KIND_BYTE |->
            o_frame_byte == '0 && o_frame_length != '0 && o_frame_length <= COUNT_LIMIT)
        else $error("bad end item fields");

    // byte items carry no length
    a_byte_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_item_kind == KIND_BYTE |-> o_frame_length == '0)
        else $error("byte item with length");

    // a processed byte with two results needs an empty queue
    a_two_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && core_out.count == 2'd2 |-> q_free == 2'd2)
        else $error("two results pushed into non-empty queue");

endmodule

// ===== tb/sv/tb_ascii_hex_sum_frame_receiver_top.sv =====
module tb_ascii_hex_sum_frame_receiver_top;
    import ahsfr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // ---------------------------------------------------------------
    // ports
    // ---------------------------------------------------------------
    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [1:0]        i_cfg_index;
    logic [BYTE_W-1:0] i_cfg_data;
    logic              i_rx_valid;
    logic              o_rx_ready;
    logic [BYTE_W-1:0] i_rx_byte;
    logic              o_res_valid;
    logic              i_res_ready = 1'b0;
    logic [1:0]        o_item_kind;
    logic [BYTE_W-1:0] o_frame_byte;
    logic [LEN_W-1:0]  o_frame_length;

    ascii_hex_sum_frame_receiver_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_rx_valid     (i_rx_valid),
        .o_rx_ready     (o_rx_ready),
        .i_rx_byte      (i_rx_byte),
        .o_res_valid    (o_res_valid),
        .i_res_ready    (i_res_ready),
        .o_item_kind    (o_item_kind),
        .o_frame_byte   (o_frame_byte),
        .o_frame_length (o_frame_length)
    );

    // 10 ns clock
    always begin
        #5;
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // stimulus table: one row is a byte request or a register write;
    // pinned rows carry a hand-typed first result
    // ---------------------------------------------------------------
    typedef struct packed {
        bit                is_cfg;
        t_cfg_index        idx;
        logic [BYTE_W-1:0] val;
        bit                pinned;
        t_result           want;
    } t_stim_row;

    // character settings used by the random phases
    typedef enum int {
        PLAN_DEFAULT,
        PLAN_ZERO,
        PLAN_ONES,
        PLAN_SHARED_START,
        PLAN_RANDOM
    } t_char_plan;

    t_stim_row directed_rows[$];

    function automatic void add_row(t_stim_row r);
        directed_rows = {directed_rows, r};
    endfunction

    // results still owed by the receiver, oldest first
    t_result awaited_items[$];
    // results of the byte request being predicted right now
    t_result byte_items[$];

    int fault_count   = 0;
    int answered_bytes = 0;
    int ready_hold    = 0;
    bit steady        = 1'b0;

    // ---------------------------------------------------------------
    // predictor: register copy and frame state
    // ---------------------------------------------------------------
    logic              pr_realtime;
    logic [BYTE_W-1:0] pr_resp_char;
    logic [BYTE_W-1:0] pr_cmd_char;
    logic [BYTE_W-1:0] pr_end_char;

    logic [LEN_W-1:0]  held_count;
    logic [BYTE_W-1:0] held_sum;
    logic [BYTE_W-1:0] tail_byte;
    logic [BYTE_W-1:0] tail_prev;
    bit                resp_open;
    bit                cmd_open;
    bit                close_pending;
    bit                overflowed;

    function automatic logic [BYTE_W-1:0] hex_ascii(logic [3:0] nib);
        if (nib < 4'd10)
            return HEX_DIGIT_BASE + 8'(nib);
        return HEX_ALPHA_BASE + 8'(nib) - 8'd10;
    endfunction

    function automatic void clear_held();
        held_count    = '0;
        held_sum      = '0;
        tail_byte     = '0;
        tail_prev     = '0;
        overflowed    = 1'b0;
        close_pending = 1'b0;
    endfunction

    function automatic void init_predictor();
        pr_realtime  = 1'b0;
        pr_resp_char = RESET_START_RESPONSE;
        pr_cmd_char  = RESET_START_COMMAND;
        pr_end_char  = RESET_END_FRAME;
        resp_open    = 1'b0;
        cmd_open     = 1'b0;
        clear_held();
    endfunction

    function automatic void apply_config(t_cfg_index idx, logic [BYTE_W-1:0] v);
        case (idx)
            CFG_REALTIME_MODE:  pr_realtime  = v[0];
            CFG_START_RESPONSE: pr_resp_char = v;
            CFG_START_COMMAND:  pr_cmd_char  = v;
            CFG_END_FRAME:      pr_end_char  = v;
            default: ;
        endcase
    endfunction

    function automatic void post_item(t_kind k, logic [BYTE_W-1:0] b, logic [LEN_W-1:0] len);
        t_result r;
        r.kind         = k;
        r.frame_byte   = b;
        r.frame_length = len;
        byte_items     = {byte_items, r};
    endfunction

    // stored byte: counted and summed until the length limit, always passed out
    function automatic void take_byte(logic [BYTE_W-1:0] b);
        if (held_count >= COUNT_LIMIT) begin
            overflowed = 1'b1;
        end else begin
            held_count = held_count + 1'b1;
            held_sum   = held_sum + b;
        end
        tail_prev = tail_byte;
        tail_byte = b;
        post_item(KIND_BYTE, b, '0);
    endfunction

    // trailing two bytes must spell the hex sum of everything before them
    function automatic t_kind frame_verdict();
        logic [BYTE_W-1:0] body_sum;
        if (overflowed || held_count < MIN_CHECKED_LEN)
            return KIND_LEN_ERR;
        body_sum = held_sum - tail_byte - tail_prev;
        if (tail_prev == hex_ascii(body_sum[7:4]) && tail_byte == hex_ascii(body_sum[3:0]))
            return KIND_GOOD;
        return KIND_SUM_ERR;
    endfunction

    function automatic void predict_rx_byte(logic [BYTE_W-1:0] b);
        if (pr_realtime) begin
            // sync nibble closes whatever is held, no checksum
            if (b[7:4] == SYNC_NIBBLE && held_count != '0) begin
                post_item(overflowed ? KIND_LEN_ERR : KIND_GOOD, '0, held_count);
                clear_held();
            end
            take_byte(b);
            return;
        end
        // response start wins over command start, which wins over end
        if (b == pr_resp_char) begin
            resp_open     = 1'b1;
            close_pending = 1'b0;
            take_byte(b);
        end else if (b == pr_cmd_char) begin
            if (!resp_open) begin
                cmd_open      = 1'b1;
                close_pending = 1'b0;
            end
            take_byte(b);
        end else if (b == pr_end_char) begin
            resp_open     = 1'b0;
            cmd_open      = 1'b0;
            close_pending = 1'b1;
        end else if ((resp_open || cmd_open) && !close_pending) begin
            take_byte(b);
        end
        // a pending close fires once something is held
        if (close_pending && !(resp_open && cmd_open) && held_count != '0) begin
            post_item(frame_verdict(), '0, held_count);
            clear_held();
        end
    endfunction

    // ---------------------------------------------------------------
    // idling: mostly short gaps, now and then a long one
    // ---------------------------------------------------------------
    function automatic int idle_span();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // result side back-pressure
    always @(negedge i_clk) begin
        if (steady) begin
            i_res_ready = 1'b1;
        end else if (ready_hold != 0) begin
            i_res_ready = 1'b0;
            ready_hold  = ready_hold - 1;
        end else if ($urandom_range(0, 4) == 0) begin
            i_res_ready = 1'b0;
            ready_hold  = idle_span() - 1;
        end else begin
            i_res_ready = 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // result checking, sampled at the rising edge
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_res_valid && i_res_ready) begin
            if (awaited_items.size() == 0) begin
                if (fault_count < 10)
                    $display("unexpected result: kind %0d byte %h len %0d",
                             o_item_kind, o_frame_byte, o_frame_length);
                fault_count++;
            end else begin
                want = awaited_items.pop_front();
                if (o_item_kind != want.kind || o_frame_byte != want.frame_byte ||
                    o_frame_length != want.frame_length) begin
                    if (fault_count < 10)
                        $display("result mismatch: kind %0d/%0d byte %h/%h len %0d/%0d (exp/got)",
                                 want.kind, o_item_kind, want.frame_byte, o_frame_byte,
                                 want.frame_length, o_frame_length);
                    fault_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // drivers: inputs change at the falling edge
    // ---------------------------------------------------------------
    task automatic send_byte(logic [BYTE_W-1:0] b, bit pinned, t_result want);
        int gap;
        gap = (!steady && $urandom_range(0, 2) == 0) ? idle_span() : 0;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        if (gap > 0) begin
            i_rx_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_rx_valid = 1'b1;
        i_rx_byte  = b;
        do @(posedge i_clk); while (!o_rx_ready);
        // request taken: work out what it must produce
        byte_items.delete();
        predict_rx_byte(b);
        if (pinned && byte_items.size() != 0)
            byte_items[0] = want;
        foreach (byte_items[k])
            awaited_items = {awaited_items, byte_items[k]};
        if (byte_items.size() != 0)
            answered_bytes++;
    endtask

    task automatic feed(logic [BYTE_W-1:0] b);
        send_byte(b, 1'b0, '0);
    endtask

    // let all owed results drain, plus the pipeline of a silent request
    task automatic settle();
        @(negedge i_clk);
        i_rx_valid = 1'b0;
        while (awaited_items.size() != 0) @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_index idx, logic [BYTE_W-1:0] v);
        @(negedge i_clk);
        i_rx_valid  = 1'b0;
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = v;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_config(idx, v);
    endtask

    // payload byte that is none of the framing characters
    function automatic logic [BYTE_W-1:0] plain_byte();
        logic [BYTE_W-1:0] b;
        b = 8'($urandom);
        while (b == pr_resp_char || b == pr_cmd_char || b == pr_end_char)
            b = 8'($urandom);
        return b;
    endfunction

    // one framed-mode frame; a flawed one misses or breaks its tail
    task automatic send_frame(bit sound);
        logic [BYTE_W-1:0] opener;
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] lo;
        int                len;
        int                flaw;
        opener = $urandom_range(0, 1) ? pr_resp_char : pr_cmd_char;
        feed(opener);
        sum = opener;
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 8);
        for (int i = 0; i < len; i++) begin
            b = plain_byte();
            feed(b);
            sum = sum + b;
        end
        lo = hex_ascii(sum[3:0]);
        if (sound) begin
            feed(hex_ascii(sum[7:4]));
            feed(lo);
            feed(pr_end_char);
        end else begin
            flaw = $urandom_range(0, 2);
            if (flaw == 1) begin
                feed(hex_ascii(sum[7:4]));
                feed(lo ^ (8'h01 << $urandom_range(0, 7)));
            end
            // flaw 2 leaves the frame open
            if (flaw != 2)
                feed(pr_end_char);
        end
    endtask

    function automatic t_stim_row rx_row(logic [BYTE_W-1:0] b);
        t_stim_row r;
        r        = '0;
        r.val    = b;
        return r;
    endfunction

    function automatic t_stim_row pin_row(logic [BYTE_W-1:0] b, t_kind k,
                                          logic [LEN_W-1:0] len);
        t_stim_row r;
        r                   = '0;
        r.val               = b;
        r.pinned            = 1'b1;
        r.want.kind         = k;
        r.want.frame_byte   = '0;
        r.want.frame_length = len;
        return r;
    endfunction

    function automatic t_stim_row cfg_row(t_cfg_index idx, logic [BYTE_W-1:0] v);
        t_stim_row r;
        r        = '0;
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.val    = v;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial begin
        t_result    len_err_full;
        t_char_plan plan;
        int         goal;
        int         target;
        int         phase;
        logic [7:0] shared;

        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_rx_valid  = 1'b0;
        i_rx_byte   = '0;
        init_predictor();

        // synchronous reset
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // idle byte with no frame open: dropped
        add_row(rx_row(8'h00));
        // response frame with correct hex sum
        add_row(rx_row(RESET_START_RESPONSE));
        add_row(rx_row(8'h41));
        add_row(rx_row(8'h34));
        add_row(rx_row(8'h32));
        add_row(pin_row(RESET_END_FRAME, KIND_GOOD, 11'd4));
        // command frame, wrong low checksum digit
        add_row(rx_row(RESET_START_COMMAND));
        add_row(rx_row(8'h42));
        add_row(rx_row(8'h35));
        add_row(rx_row(8'h41));
        add_row(pin_row(RESET_END_FRAME, KIND_SUM_ERR, 11'd4));
        // short frame
        add_row(rx_row(RESET_START_RESPONSE));
        add_row(pin_row(RESET_END_FRAME, KIND_LEN_ERR, 11'd1));
        // command start and a second response start inside a response frame
        add_row(rx_row(RESET_START_RESPONSE));
        add_row(rx_row(RESET_START_COMMAND));
        add_row(rx_row(RESET_START_RESPONSE));
        add_row(rx_row(8'hFF));
        add_row(rx_row(8'h31));
        add_row(rx_row(8'h43));
        add_row(pin_row(RESET_END_FRAME, KIND_GOOD, 11'd6));
        // realtime: first sync byte has nothing to close, second one does
        add_row(cfg_row(CFG_REALTIME_MODE, 8'd1));
        add_row(rx_row(8'hD0));
        add_row(rx_row(8'h7F));
        add_row(pin_row(8'hDF, KIND_GOOD, 11'd2));
        // back to framed with one byte held: end char closes it at once
        add_row(cfg_row(CFG_REALTIME_MODE, 8'd0));
        add_row(pin_row(RESET_END_FRAME, KIND_LEN_ERR, 11'd1));
        // end char with nothing held leaves the close pending across modes
        add_row(rx_row(RESET_END_FRAME));
        add_row(cfg_row(CFG_REALTIME_MODE, 8'd1));
        add_row(rx_row(8'h10));
        add_row(cfg_row(CFG_REALTIME_MODE, 8'd0));
        add_row(pin_row(8'h99, KIND_LEN_ERR, 11'd1));

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg) begin
                settle();
                write_reg(directed_rows[i].idx, directed_rows[i].val);
            end else begin
                send_byte(directed_rows[i].val, directed_rows[i].pinned,
                          directed_rows[i].want);
            end
        end

        // overflowed frames: one closed by the end char, one by a sync byte
        len_err_full.kind         = KIND_LEN_ERR;
        len_err_full.frame_byte   = '0;
        len_err_full.frame_length = COUNT_LIMIT;
        feed(RESET_START_RESPONSE);
        for (int i = 0; i < COUNT_LIMIT_INT; i++)
            feed(8'($urandom_range(8'h20, 8'h7E)));
        send_byte(RESET_END_FRAME, 1'b1, len_err_full);

        settle();
        write_reg(CFG_REALTIME_MODE, 8'd1);
        for (int i = 0; i <= COUNT_LIMIT_INT; i++)
            feed(8'($urandom_range(8'h20, 8'h7E)));
        send_byte(8'hD3, 1'b1, len_err_full);

        // random phases, each with its own character setting and mode
        target = answered_bytes + 1050;
        phase  = 0;
        while (answered_bytes < target) begin
            settle();
            if (phase <= int'(PLAN_RANDOM))
                plan = t_char_plan'(phase);
            else if ($urandom_range(0, 9) < 3)
                plan = PLAN_DEFAULT;
            else if ($urandom_range(0, 9) == 0)
                plan = PLAN_SHARED_START;
            else
                plan = PLAN_RANDOM;
            shared = 8'($urandom);
            case (plan)
                PLAN_DEFAULT: begin
                    write_reg(CFG_START_RESPONSE, RESET_START_RESPONSE);
                    write_reg(CFG_START_COMMAND, RESET_START_COMMAND);
                    write_reg(CFG_END_FRAME, RESET_END_FRAME);
                end
                PLAN_ZERO: begin
                    write_reg(CFG_START_RESPONSE, 8'h00);
                    write_reg(CFG_START_COMMAND, 8'h00);
                    write_reg(CFG_END_FRAME, 8'h00);
                end
                PLAN_ONES: begin
                    write_reg(CFG_START_RESPONSE, 8'hFF);
                    write_reg(CFG_START_COMMAND, 8'hFF);
                    write_reg(CFG_END_FRAME, 8'hFF);
                end
                PLAN_SHARED_START: begin
                    write_reg(CFG_START_RESPONSE, shared);
                    write_reg(CFG_START_COMMAND, shared);
                    write_reg(CFG_END_FRAME, 8'($urandom));
                end
                default: begin
                    write_reg(CFG_START_RESPONSE, 8'($urandom));
                    write_reg(CFG_START_COMMAND, 8'($urandom));
                    write_reg(CFG_END_FRAME, 8'($urandom));
                end
            endcase
            // upper bits of the mode write are don't-care
            write_reg(CFG_REALTIME_MODE,
                      {7'($urandom), ($urandom_range(0, 2) == 0) ? 1'b1 : 1'b0});
            steady = ($urandom_range(0, 3) == 0);

            goal = answered_bytes + $urandom_range(40, 120);
            while (answered_bytes < goal) begin
                if (pr_realtime) begin
                    if ($urandom_range(0, 6) == 0)
                        feed({SYNC_NIBBLE, 4'($urandom)});
                    else
                        feed(8'($urandom));
                end else begin
                    case ($urandom_range(0, 9))
                        7:       send_frame(1'b0);
                        8, 9:    feed(8'($urandom));
                        default: send_frame(1'b1);
                    endcase
                end
            end
            phase++;
        end

        // drain, then wait for stray results
        @(negedge i_clk);
        i_rx_valid  = 1'b0;
        i_cfg_valid = 1'b0;
        steady      = 1'b0;
        while (awaited_items.size() != 0) @(negedge i_clk);
        repeat (10) @(posedge i_clk);

        if (fault_count == 0)
            $display("tb_ascii_hex_sum_frame_receiver_top OK");
        else
            $display("tb_ascii_hex_sum_frame_receiver_top NOT OK");
        $finish;
    end

    // run limit, far above the slowest legal run
    initial begin
        #30_000_000;
        $display("tb_ascii_hex_sum_frame_receiver_top NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
design/ahsfr_pkg.sv
design/ahsfr_cfg.sv
design/ahsfr_core.sv
design/ahsfr_outq.sv
design/ascii_hex_sum_frame_receiver_top.sv
tb/sv/tb_ascii_hex_sum_frame_receiver_top.sv
